### hdl/nfr_pkg.sv
// Shared types and constants of the nitrogen fixation rate pipeline.
// Depends on nothing; every other file of the block imports it.
package nfr_pkg;

   // Quotient bits of the temperature-ramp divider and of the cost divider.
   localparam int TEMP_QBITS = 15;
   localparam int QUOT_BITS  = 32;

   // Unity in Q1.15.
   localparam logic [15:0] ONE_Q15 = 16'h8000;

   // How the temperature response of one layer is formed.
   localparam logic [1:0] TMODE_ZERO = 2'd0;
   localparam logic [1:0] TMODE_ONE  = 2'd1;
   localparam logic [1:0] TMODE_DIV  = 2'd2;

   typedef struct packed {
      logic [31:0] temp_lower;
      logic [31:0] temp_upper;
      logic [31:0] swc_bounds;
      logic [31:0] water_line;
      logic [23:0] nfix;
      logic [23:0] cost;
      logic [15:0] max_frac;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] num;
      logic [15:0] den;
   } tdiv_type;

   typedef struct packed {
      tdiv_type           tdiv;
      logic signed [32:0] wprod;
      logic               win;
      logic               wfull;
      logic [24:0]        rate;
   } front_type;

   typedef struct packed {
      logic [24:0] rate0;
      logic [24:0] rate1;
      logic [15:0] fw0;
      logic [15:0] fw1;
      logic [31:0] deficit;
      logic [31:0] npp;
   } tside_type;

   typedef struct packed {
      logic [25:0] fix;
      logic [31:0] req;
      logic        dlim;
      logic        clim;
   } cside_type;

endpackage

### hdl/nfr_layer_front.sv
// First pipeline stage of one soil layer: temperature band decode, water product
// and root-scaled potential rate. Depends on nfr_pkg.
module nfr_layer_front (
   input  logic                clock,
   input  logic                en,
   input  logic signed [14:0]  temp,
   input  logic [15:0]         swc,
   input  logic [15:0]         root_frac,
   input  nfr_pkg::cfg_type    cfg,
   output nfr_pkg::front_type  front
);
   import nfr_pkg::*;

   front_type          front_ff;
   front_type          front_in;
   logic signed [16:0] t_x, lo, os, oe, hi;
   logic signed [16:0] rise_num, rise_den, fall_num, fall_den;
   logic               rise, flat, fall;
   logic signed [15:0] slope;
   logic signed [16:0] swc_s;
   logic [15:0]        dry, wet;
   logic [39:0]        rate_prod;

   always_comb begin
      t_x = {{2{temp[14]}}, temp};
      lo  = {cfg.temp_lower[15], cfg.temp_lower[15:0]};
      os  = {cfg.temp_lower[31], cfg.temp_lower[31:16]};
      oe  = {cfg.temp_upper[15], cfg.temp_upper[15:0]};
      hi  = {cfg.temp_upper[31], cfg.temp_upper[31:16]};

      rise = (t_x >= lo) && (t_x < os);
      flat = (t_x >= os) && (t_x <= oe);
      fall = (t_x > oe) && (t_x <= hi);

      rise_num = t_x - lo;
      rise_den = os - lo;
      fall_num = hi - t_x;
      fall_den = hi - oe;

      // The falling edge wins over the others, as the bands are tested in order.
      front_in.tdiv.mode = TMODE_ZERO;
      front_in.tdiv.num  = rise_num[15:0];
      front_in.tdiv.den  = rise_den[15:0];
      if (fall) begin
         front_in.tdiv.mode = TMODE_DIV;
         front_in.tdiv.num  = fall_num[15:0];
         front_in.tdiv.den  = fall_den[15:0];
      end else if (flat) begin
         front_in.tdiv.mode = TMODE_ONE;
      end else if (rise) begin
         front_in.tdiv.mode = TMODE_DIV;
      end

      dry            = cfg.swc_bounds[15:0];
      wet            = cfg.swc_bounds[31:16];
      slope          = cfg.water_line[31:16];
      swc_s          = {1'b0, swc};
      front_in.wprod = slope * swc_s;
      front_in.win   = (swc > dry) && (swc < wet);
      front_in.wfull = (swc >= wet);

      rate_prod     = cfg.nfix * root_frac;
      front_in.rate = rate_prod[39:15];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

### hdl/nfr_temp_div.sv
// Restoring fraction divider for the temperature ramps of both layers, one
// quotient bit per stage, with the remaining payload carried alongside. Depends on nfr_pkg.
module nfr_temp_div (
   input  logic                     clock,
   input  logic                     en,
   input  nfr_pkg::tdiv_type [1:0]  div_in,
   input  nfr_pkg::tside_type       side_in,
   output logic [1:0][15:0]         ftemp,
   output nfr_pkg::tside_type       side_out
);
   import nfr_pkg::*;

   typedef struct packed {
      logic [1:0]            mode;
      logic [15:0]           den;
      logic [15:0]           rem;
      logic [TEMP_QBITS-1:0] quo;
   } tstep_type;

   tstep_type [1:0] stage_ff [TEMP_QBITS];
   tside_type       side_ff  [TEMP_QBITS];
   tstep_type [1:0] init;

   function automatic tstep_type div_step(tstep_type s);
      logic [16:0] r2;
      tstep_type   n;
      n  = s;
      r2 = {s.rem, 1'b0};
      if (r2 >= {1'b0, s.den}) begin
         n.rem = 16'(r2 - {1'b0, s.den});
         n.quo = {s.quo[TEMP_QBITS-2:0], 1'b1};
      end else begin
         n.rem = r2[15:0];
         n.quo = {s.quo[TEMP_QBITS-2:0], 1'b0};
      end
      return n;
   endfunction

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         init[l].mode = div_in[l].mode;
         init[l].den  = div_in[l].den;
         init[l].rem  = div_in[l].num;
         init[l].quo  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 2; l++) begin
            stage_ff[0][l] <= div_step(init[l]);
            for (int k = 1; k < TEMP_QBITS; k++) begin
               stage_ff[k][l] <= div_step(stage_ff[k-1][l]);
            end
         end
         side_ff[0] <= side_in;
         for (int k = 1; k < TEMP_QBITS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         case (stage_ff[TEMP_QBITS-1][l].mode)
            TMODE_ONE: ftemp[l] = ONE_Q15;
            TMODE_DIV: ftemp[l] = 16'(stage_ff[TEMP_QBITS-1][l].quo);
            default:   ftemp[l] = '0;
         endcase
      end
   end

   assign side_out = side_ff[TEMP_QBITS-1];

endmodule

### hdl/nfr_cost_div.sv
// Restoring divider of the cost-ceiling fixation, one quotient bit per stage,
// with the result payload carried alongside. Depends on nfr_pkg.
module nfr_cost_div (
   input  logic                clock,
   input  logic                en,
   input  logic [48:0]         dividend,
   input  logic [23:0]         cost,
   input  nfr_pkg::cside_type  side_in,
   output logic [31:0]         quotient,
   output nfr_pkg::cside_type  side_out
);
   import nfr_pkg::*;

   typedef struct packed {
      logic [23:0]          rem;
      logic [QUOT_BITS-1:0] quo;
      logic [QUOT_BITS-1:0] low;
   } cstep_type;

   cstep_type stage_ff [QUOT_BITS];
   cside_type side_ff  [QUOT_BITS];
   cstep_type init;

   function automatic cstep_type div_step(cstep_type s, logic [23:0] d);
      logic [24:0] r2;
      cstep_type   n;
      n     = s;
      r2    = {s.rem, s.low[QUOT_BITS-1]};
      n.low = {s.low[QUOT_BITS-2:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
         n.rem = 24'(r2 - {1'b0, d});
         n.quo = {s.quo[QUOT_BITS-2:0], 1'b1};
      end else begin
         n.rem = r2[23:0];
         n.quo = {s.quo[QUOT_BITS-2:0], 1'b0};
      end
      return n;
   endfunction

   always_comb begin
      init.rem = {7'd0, dividend[48:32]};
      init.quo = '0;
      init.low = dividend[31:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= div_step(init, cost);
         side_ff[0]  <= side_in;
         for (int k = 1; k < QUOT_BITS; k++) begin
            stage_ff[k] <= div_step(stage_ff[k-1], cost);
            side_ff[k]  <= side_ff[k-1];
         end
      end
   end

   assign quotient = stage_ff[QUOT_BITS-1].quo;
   assign side_out = side_ff[QUOT_BITS-1];

endmodule

### hdl/nitrogen_fixation_rate_core.sv
// Top level of the nitrogen fixation rate pipeline: configuration registers,
// multiply stages and the output register. Depends on nfr_pkg and the nfr_ modules.
//
// The core accepts one request per clock cycle unless stalled and returns one
// response per request, in order. The pipeline holds one front stage, fifteen stages
// of the temperature-ramp divider (one quotient bit each), four multiply and compare
// stages, thirty-two stages of the cost-ceiling divider and the output register.
// A stall on the response side freezes the whole pipeline, so nothing is lost or
// repeated; the request side is stalled only while a finished response waits.
// Configuration registers must be written through the csr_ port only while the core
// is idle, which the core itself does not enforce; they take effect for every later
// request.
module nitrogen_fixation_rate_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [14:0] req_temp_top,
   input  logic signed [14:0] req_temp_second,
   input  logic [15:0]        req_swc_top,
   input  logic [15:0]        req_swc_second,
   input  logic [15:0]        req_root_frac_top,
   input  logic [15:0]        req_root_frac_second,
   input  logic [31:0]        req_n_deficit,
   input  logic [31:0]        req_npp_available,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_fixed_nitrogen,
   output logic [31:0]        rsp_npp_required,
   output logic               rsp_deficit_limited,
   output logic               rsp_cost_limited,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import nfr_pkg::*;

   localparam logic [2:0] REG_TEMP_LOWER = 3'd0;
   localparam logic [2:0] REG_TEMP_UPPER = 3'd1;
   localparam logic [2:0] REG_SWC_BOUNDS = 3'd2;
   localparam logic [2:0] REG_WATER_LINE = 3'd3;
   localparam logic [2:0] REG_NFIX       = 3'd4;
   localparam logic [2:0] REG_COST       = 3'd5;
   localparam logic [2:0] REG_MAX_FRAC   = 3'd6;

   // Front stage, divider stages, four arithmetic stages, divider, output.
   localparam int LAT = 1 + TEMP_QBITS + 4 + QUOT_BITS + 1;

   cfg_type          cfg_ff, cfg_in;
   logic [LAT-1:0]   valid_ff;
   logic             en;

   front_type        front_top, front_second;
   logic [31:0]      deficit_a_ff, npp_a_ff;
   logic [15:0]      fw_top, fw_second;
   tside_type        tside_in, tside_out;
   logic [1:0][15:0] ftemp;

   logic [40:0]      m1_prod0, m1_prod1;
   logic [24:0]      b0_ff, b1_ff;
   logic [15:0]      fw0_b_ff, fw1_b_ff;
   logic [31:0]      deficit_b_ff, npp_b_ff;

   logic [40:0]      m2_prod0, m2_prod1;
   logic [24:0]      c0_ff, c1_ff;
   logic [31:0]      deficit_c_ff, npp_c_ff;

   logic [25:0]      sum_in, fix_s_ff, fix_s_in;
   logic             dlim_s_ff, dlim_s_in;
   logic [47:0]      ceil_prod;
   logic [32:0]      ceil_s_ff;

   logic [49:0]      req_prod;
   logic [25:0]      fix_r_ff;
   logic             dlim_r_ff;
   logic [32:0]      ceil_r_ff;
   logic [33:0]      req_r_ff;

   cside_type        cside_in, cside_out;
   logic [31:0]      quotient;

   logic [31:0]      rsp_fixed_nitrogen_ff, rsp_npp_required_ff;
   logic             rsp_deficit_limited_ff, rsp_cost_limited_ff;

   // The pipeline moves as one unless a finished response is held back.
   assign en        = !(valid_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = valid_ff[LAT-1];

   // Configuration decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_TEMP_LOWER: cfg_in.temp_lower = csr_data;
            REG_TEMP_UPPER: cfg_in.temp_upper = csr_data;
            REG_SWC_BOUNDS: cfg_in.swc_bounds = csr_data;
            REG_WATER_LINE: cfg_in.water_line = csr_data;
            REG_NFIX:       cfg_in.nfix       = csr_data[23:0];
            REG_COST:       cfg_in.cost       = csr_data[23:0];
            REG_MAX_FRAC:   cfg_in.max_frac   = csr_data[15:0];
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // Every configuration register clears except the cost, which resets to one.
         cfg_ff          <= '{cost: 24'h010000, default: '0};
         valid_ff        <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (en) begin
            valid_ff <= {valid_ff[LAT-2:0], req_valid};
         end
      end
   end

   // Front stage of both layers.
   nfr_layer_front u_front_top (
      .clock     (clock),
      .en        (en),
      .temp      (req_temp_top),
      .swc       (req_swc_top),
      .root_frac (req_root_frac_top),
      .cfg       (cfg_ff),
      .front     (front_top)
   );

   nfr_layer_front u_front_second (
      .clock     (clock),
      .en        (en),
      .temp      (req_temp_second),
      .swc       (req_swc_second),
      .root_frac (req_root_frac_second),
      .cfg       (cfg_ff),
      .front     (front_second)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         deficit_a_ff <= req_n_deficit;
         npp_a_ff     <= req_npp_available;
      end
   end

   // Water response: the ramp is floored, offset by the intercept and held to
   // the range nothing to unity; soil at or above the wet bound gives unity.
   function automatic logic [15:0] water_resp(front_type f, logic [31:0] line);
      logic signed [21:0] icpt8;
      logic signed [21:0] ramp;
      logic signed [21:0] total;
      logic [15:0]        fw;
      icpt8 = {{3{line[15]}}, line[15:0], 3'b000};
      ramp  = {f.wprod[32], f.wprod[32:12]};
      total = icpt8 + ramp;
      fw    = '0;
      if (f.wfull) begin
         fw = ONE_Q15;
      end else if (f.win) begin
         if (total < 22'sd0) begin
            fw = '0;
         end else if (total > 22'sd32768) begin
            fw = ONE_Q15;
         end else begin
            fw = total[15:0];
         end
      end
      return fw;
   endfunction

   always_comb begin
      fw_top            = water_resp(front_top, cfg_ff.water_line);
      fw_second         = water_resp(front_second, cfg_ff.water_line);
      tside_in.rate0    = front_top.rate;
      tside_in.rate1    = front_second.rate;
      tside_in.fw0      = fw_top;
      tside_in.fw1      = fw_second;
      tside_in.deficit  = deficit_a_ff;
      tside_in.npp      = npp_a_ff;
   end

   nfr_temp_div u_temp_div (
      .clock    (clock),
      .en       (en),
      .div_in   ({front_second.tdiv, front_top.tdiv}),
      .side_in  (tside_in),
      .ftemp    (ftemp),
      .side_out (tside_out)
   );

   // Temperature scaling of the layer rates.
   assign m1_prod0 = tside_out.rate0 * ftemp[0];
   assign m1_prod1 = tside_out.rate1 * ftemp[1];

   always_ff @(posedge clock) begin
      if (en) begin
         b0_ff        <= m1_prod0[39:15];
         b1_ff        <= m1_prod1[39:15];
         fw0_b_ff     <= tside_out.fw0;
         fw1_b_ff     <= tside_out.fw1;
         deficit_b_ff <= tside_out.deficit;
         npp_b_ff     <= tside_out.npp;
      end
   end

   // Water scaling of the layer rates.
   assign m2_prod0 = b0_ff * fw0_b_ff;
   assign m2_prod1 = b1_ff * fw1_b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c0_ff        <= m2_prod0[39:15];
         c1_ff        <= m2_prod1[39:15];
         deficit_c_ff <= deficit_b_ff;
         npp_c_ff     <= npp_b_ff;
      end
   end

   // Sum of the layers, deficit clamp and the NPP ceiling side by side.
   always_comb begin
      sum_in    = {1'b0, c0_ff} + {1'b0, c1_ff};
      fix_s_in  = sum_in;
      dlim_s_in = 1'b0;
      if ({6'd0, sum_in} > deficit_c_ff) begin
         fix_s_in  = deficit_c_ff[25:0];
         dlim_s_in = 1'b1;
      end
      ceil_prod = npp_c_ff * cfg_ff.max_frac;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fix_s_ff  <= fix_s_in;
         dlim_s_ff <= dlim_s_in;
         ceil_s_ff <= ceil_prod[47:15];
      end
   end

   // Carbon cost of the fixation.
   assign req_prod = cfg_ff.cost * fix_s_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         fix_r_ff  <= fix_s_ff;
         dlim_r_ff <= dlim_s_ff;
         ceil_r_ff <= ceil_s_ff;
         req_r_ff  <= req_prod[49:16];
      end
   end

   // The ceiling binds when the cost exceeds it; a zero cost never binds.
   // The spend is saturated here so that only the quotient is left to form.
   always_comb begin
      cside_in.fix  = fix_r_ff;
      cside_in.dlim = dlim_r_ff;
      cside_in.clim = (req_r_ff > {1'b0, ceil_r_ff}) && (cfg_ff.cost != '0);
      if (cside_in.clim) begin
         cside_in.req = ceil_r_ff[32] ? '1 : ceil_r_ff[31:0];
      end else begin
         cside_in.req = (req_r_ff[33:32] != 2'b00) ? '1 : req_r_ff[31:0];
      end
   end

   nfr_cost_div u_cost_div (
      .clock    (clock),
      .en       (en),
      .dividend ({ceil_r_ff, 16'd0}),
      .cost     (cfg_ff.cost),
      .side_in  (cside_in),
      .quotient (quotient),
      .side_out (cside_out)
   );

   // Output register. When the ceiling binds the recomputed fixation is below
   // the clamped one, so its quotient always fits the response field.
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_fixed_nitrogen_ff  <= cside_out.clim ? quotient : {6'd0, cside_out.fix};
         rsp_npp_required_ff    <= cside_out.req;
         rsp_deficit_limited_ff <= cside_out.dlim;
         rsp_cost_limited_ff    <= cside_out.clim;
      end
   end

   assign rsp_fixed_nitrogen  = rsp_fixed_nitrogen_ff;
   assign rsp_npp_required    = rsp_npp_required_ff;
   assign rsp_deficit_limited = rsp_deficit_limited_ff;
   assign rsp_cost_limited    = rsp_cost_limited_ff;

endmodule

### sim/tb_nitrogen_fixation_rate_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for nitrogen_fixation_rate_core: directed soil samples, then
// randomised phases under several register settings. Depends on nfr_pkg and the core.
module tb_nitrogen_fixation_rate_core;
   import nfr_pkg::*;

   // Register map of the csr_ port.
   localparam logic [2:0] REG_TEMP_LOWER = 3'd0;
   localparam logic [2:0] REG_TEMP_UPPER = 3'd1;
   localparam logic [2:0] REG_SWC_BOUNDS = 3'd2;
   localparam logic [2:0] REG_WATER_LINE = 3'd3;
   localparam logic [2:0] REG_NFIX       = 3'd4;
   localparam logic [2:0] REG_COST       = 3'd5;
   localparam logic [2:0] REG_MAX_FRAC   = 3'd6;

   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int STALL_LIMIT  = 3000;  // cycles without any handshake
   localparam int ROWS         = 20;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 160;

   typedef struct {
      logic signed [14:0] t0, t1;
      logic [15:0]        s0, s1, r0, r1;
      logic [31:0]        deficit, npp;
   } soil_sample_type;

   typedef struct {
      logic [31:0] fix, req;
      logic        dlim, clim;
   } fixation_type;

   typedef struct {
      soil_sample_type smp;
      bit              typed;
      fixation_type    golden;
   } stim_row_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic signed [14:0] req_temp_top, req_temp_second;
   logic [15:0] req_swc_top, req_swc_second, req_root_frac_top, req_root_frac_second;
   logic [31:0] req_n_deficit, req_npp_available;
   logic rsp_valid, rsp_stall;
   logic [31:0] rsp_fixed_nitrogen, rsp_npp_required;
   logic rsp_deficit_limited, rsp_cost_limited;
   logic csr_write;
   logic [2:0] csr_index;
   logic [31:0] csr_data;

   nitrogen_fixation_rate_core dut (.*);

   // The testbench's own copy of the registers, reset values included.
   bit [31:0] cfg_tlow, cfg_tup, cfg_swc, cfg_wline;
   bit [23:0] cfg_nfix, cfg_cost = 24'h010000;
   bit [15:0] cfg_frac;

   fixation_type    pending_fixation[$];
   stim_row_type    directed_rows[ROWS];
   int  mismatches, requests_sent, responses_seen, dlim_seen, clim_seen;
   bit  quiet;          // sender and receiver draw no random idle gaps while set
   bit  hold_off_req;   // asks the receiver for one long hold-off

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Trapezoidal temperature response in Q1.15; later conditions override earlier ones.
   function automatic longint temp_gain(input int t);
      int lo, os, oe, hi;
      longint f;
      lo = $signed(cfg_tlow[15:0]);
      os = $signed(cfg_tlow[31:16]);
      oe = $signed(cfg_tup[15:0]);
      hi = $signed(cfg_tup[31:16]);
      f  = 0;
      if (t >= lo && t < os) f = (longint'(t - lo) * 32768) / longint'(os - lo);
      if (t >= os && t <= oe) f = 32768;
      if (t > oe && t <= hi) f = (longint'(hi - t) * 32768) / longint'(hi - oe);
      return f;
   endfunction

   // Clamped linear water ramp; the product is floored by the arithmetic shift.
   function automatic longint water_gain(input int swc);
      int dry, wet;
      longint icpt, slope, f;
      dry   = cfg_swc[15:0];
      wet   = cfg_swc[31:16];
      icpt  = $signed(cfg_wline[15:0]);
      slope = $signed(cfg_wline[31:16]);
      f     = 0;
      if (swc > dry && swc < wet) begin
         f = icpt * 8 + ((slope * swc) >>> 12);
         if (f < 0) f = 0;
         if (f > 32768) f = 32768;
      end
      if (swc >= wet) f = 32768;
      return f;
   endfunction

   function automatic bit [63:0] layer_fixation(input int t, input int swc, input int root);
      bit [63:0] a;
      a = (64'(cfg_nfix) * 64'(root)) >> 15;
      a = (a * 64'(temp_gain(t))) >> 15;
      a = (a * 64'(water_gain(swc))) >> 15;
      return a;
   endfunction

   function automatic fixation_type fixation_outcome(input soil_sample_type s);
      bit [63:0] fix, req, ceiling;
      fixation_type r;
      r.dlim = 1'b0;
      r.clim = 1'b0;
      fix = layer_fixation(s.t0, s.s0, s.r0) + layer_fixation(s.t1, s.s1, s.r1);
      if (fix > 64'(s.deficit)) begin
         fix    = 64'(s.deficit);
         r.dlim = 1'b1;
      end
      req     = (64'(cfg_cost) * fix) >> 16;
      ceiling = (64'(s.npp) * 64'(cfg_frac)) >> 15;
      // A zero cost never binds the ceiling, so there is no division by zero.
      if (req > ceiling && cfg_cost != 0) begin
         req    = ceiling;
         fix    = (ceiling << 16) / 64'(cfg_cost);
         r.clim = 1'b1;
      end
      r.fix = (fix > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : fix[31:0];
      r.req = (req > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : req[31:0];
      return r;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         REG_TEMP_LOWER: cfg_tlow  = data;
         REG_TEMP_UPPER: cfg_tup   = data;
         REG_SWC_BOUNDS: cfg_swc   = data;
         REG_WATER_LINE: cfg_wline = data;
         REG_NFIX:       cfg_nfix  = data[23:0];
         REG_COST:       cfg_cost  = data[23:0];
         REG_MAX_FRAC:   cfg_frac  = data[15:0];
         default: ;
      endcase
   endtask

   // Offers one request and records its expected response once accepted. The valid
   // line is left high on return so that back-to-back requests need no extra edge.
   task automatic offer(input soil_sample_type s, input bit typed, input fixation_type golden);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_temp_top         = s.t0;
      req_temp_second      = s.t1;
      req_swc_top          = s.s0;
      req_swc_second       = s.s1;
      req_root_frac_top    = s.r0;
      req_root_frac_second = s.r1;
      req_n_deficit        = s.deficit;
      req_npp_available    = s.npp;
      req_valid            = 1'b1;
      do @(posedge clock); while (req_stall);
      pending_fixation.push_back(typed ? golden : fixation_outcome(s));
      requests_sent++;
      @(negedge clock);
   endtask

   // Waits until every response has come back, then lets the pipeline settle.
   // Called at a falling edge, so the valid line drops before the next rising one.
   task automatic drain();
      req_valid = 1'b0;
      while (pending_fixation.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic soil_sample_type pack_sample(input int t0, input int t1, input int s0,
      input int s1, input int r0, input int r1, input logic [31:0] d, input logic [31:0] n);
      soil_sample_type s;
      s.t0 = 15'(t0); s.t1 = 15'(t1);
      s.s0 = 16'(s0); s.s1 = 16'(s1); s.r0 = 16'(r0); s.r1 = 16'(r1);
      s.deficit = d; s.npp = n;
      return s;
   endfunction

   function automatic int random_temp();
      int pick;
      pick = $urandom_range(0, 9);
      // Now and then land exactly on one of the trapezoid's corners.
      case (pick)
         0: return $signed(cfg_tlow[15:0]);
         1: return $signed(cfg_tlow[31:16]);
         2: return $signed(cfg_tup[15:0]);
         3: return $signed(cfg_tup[31:16]);
         default: return int'($urandom_range(0, 28160)) - 12800;
      endcase
   endfunction

   function automatic int random_swc();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return cfg_swc[15:0];
         1: return cfg_swc[31:16];
         2: return 32768;
         default: return $urandom_range(0, 32768);
      endcase
   endfunction

   function automatic soil_sample_type random_sample();
      soil_sample_type s;
      s = pack_sample(random_temp(), random_temp(), random_swc(), random_swc(),
                      $urandom_range(0, 32768), $urandom_range(0, 32768), 0, 0);
      // Most deficits and NPP values sit where the clamps can go either way.
      s.deficit = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0200_0000);
      s.npp     = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0400_0000);
      return s;
   endfunction

   // Random register setting, well-formed but in phase 3; phases pick extremes on top of it.
   task automatic random_config(input int phase);
      int p[4], tmp;
      int dry, wet;
      for (int i = 0; i < 4; i++) p[i] = int'($urandom_range(0, 28160)) - 12800;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3 - i; j++)
            if (p[j] > p[j + 1]) begin
               tmp = p[j]; p[j] = p[j + 1]; p[j + 1] = tmp;
            end
      // Phase 3 runs with reversed points, evaluated literally by the core.
      if (phase == 3) begin
         tmp = p[0]; p[0] = p[3]; p[3] = tmp;
      end
      write_reg(REG_TEMP_LOWER, {p[1][15:0], p[0][15:0]});
      write_reg(REG_TEMP_UPPER, {p[3][15:0], p[2][15:0]});
      dry = $urandom_range(0, 16384);
      wet = $urandom_range(dry, 32768);
      if (phase == 3) write_reg(REG_SWC_BOUNDS, {16'(dry), 16'(wet)});
      else write_reg(REG_SWC_BOUNDS, {16'(wet), 16'(dry)});
      if (phase == 5) write_reg(REG_WATER_LINE, $urandom());
      else write_reg(REG_WATER_LINE, {16'($urandom_range(0, 32767)),
                                      16'(int'($urandom_range(0, 8192)) - 4096)});
      case (phase)
         0: write_reg(REG_NFIX, 32'h00FF_FFFF);
         1: write_reg(REG_NFIX, 32'h0000_0000);
         default: write_reg(REG_NFIX, $urandom_range(1, 32'h00FF_FFFF));
      endcase
      case (phase)
         0: write_reg(REG_COST, 32'h0000_0001);
         2: write_reg(REG_COST, 32'h00FF_FFFF);
         6: write_reg(REG_COST, 32'h0000_0000);
         default: write_reg(REG_COST, $urandom_range(1, 32'h0008_0000));
      endcase
      case (phase)
         0: write_reg(REG_MAX_FRAC, 32'h0000_8000);
         4: write_reg(REG_MAX_FRAC, 32'h0000_0000);
         default: write_reg(REG_MAX_FRAC, $urandom_range(0, 32768));
      endcase
   endtask

   // Receiver: draws a stall for every response and honours one long hold-off.
   initial begin
      int wait_cycles;
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end
         wait_cycles = quiet ? 0 : $urandom_range(0, 13);
         if (wait_cycles != 0) begin
            rsp_stall = 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Response checker: every accepted response is matched against the oldest expectation.
   always @(posedge clock) begin
      fixation_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (pending_fixation.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response fix=%h", rsp_fixed_nitrogen);
         end else begin
            e = pending_fixation.pop_front();
            if (rsp_deficit_limited) dlim_seen++;
            if (rsp_cost_limited) clim_seen++;
            if (rsp_fixed_nitrogen !== e.fix || rsp_npp_required !== e.req ||
                rsp_deficit_limited !== e.dlim || rsp_cost_limited !== e.clim) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d: fix %h/%h req %h/%h dlim %b/%b clim %b/%b (exp/got)",
                     responses_seen, e.fix, rsp_fixed_nitrogen, e.req, rsp_npp_required,
                     e.dlim, rsp_deficit_limited, e.clim, rsp_cost_limited);
            end
         end
      end
   end

   // Watchdog: ends a run in which no handshake happens for too long.
   always @(posedge clock) begin
      int idle_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("nitrogen_fixation_rate_core test failed");
         $finish;
      end
   end

   initial begin
      fixation_type zero_out;
      zero_out = '{fix: 32'd0, req: 32'd0, dlim: 1'b0, clim: 1'b0};

      // Reset configuration: nfix is zero, so every response is all zeros.
      directed_rows[0] = '{pack_sample(-12800, -12800, 0, 0, 0, 0, 0, 0), 1'b1, zero_out};
      directed_rows[1] = '{pack_sample(15360, 15360, 32768, 32768, 32768, 32768,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, zero_out};
      directed_rows[2] = '{pack_sample(0, -1, 16'h5555, 16'h2AAA, 16'h7FFF, 16'h0001,
                           32'hAAAA_AAAA, 32'h5555_5555), 1'b1, zero_out};
      // Trapezoid -5..10..25..40 C, water 0.125..0.75, unit-slope ramp, cost 2, fraction 0.5.
      // Below the lower limit in both layers nothing is fixed at all.
      directed_rows[3] = '{pack_sample(-1281, -12800, 32768, 32768, 32768, 32768,
                           32'h1000_0000, 32'h1000_0000), 1'b1, zero_out};
      directed_rows[4] = '{pack_sample(-1280, 2560, 32768, 32768, 32768, 32768,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, zero_out};
      directed_rows[5] = '{pack_sample(0, 2559, 32768, 32768, 32768, 32768,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, zero_out};
      directed_rows[6] = '{pack_sample(6400, 6401, 32768, 32768, 32768, 32768,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, zero_out};
      directed_rows[7] = '{pack_sample(10240, 10241, 32768, 32768, 32768, 32768,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, zero_out};
      directed_rows[8] = '{pack_sample(5000, 5000, 16'h1000, 16'h1001, 32768, 32768,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, zero_out};
      directed_rows[9] = '{pack_sample(5000, 5000, 16'h5FFF, 16'h6000, 32768, 32768,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, zero_out};
      directed_rows[10] = '{pack_sample(5000, 5000, 16'h3000, 0, 32768, 0,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, zero_out};
      // The deficit clamp binds, and with a zero deficit nothing is fixed.
      directed_rows[11] = '{pack_sample(5000, 5000, 32768, 32768, 32768, 32768,
                            32'h0000_1234, 32'hFFFF_FFFF), 1'b0, zero_out};
      directed_rows[12] = '{pack_sample(5000, 5000, 32768, 32768, 32768, 32768,
                            0, 32'hFFFF_FFFF), 1'b1, '{32'd0, 32'd0, 1'b1, 1'b0}};
      // The cost ceiling binds; with no NPP at all fixation falls to zero.
      directed_rows[13] = '{pack_sample(5000, 5000, 32768, 32768, 32768, 32768,
                            32'hFFFF_FFFF, 32'h0001_0000), 1'b0, zero_out};
      directed_rows[14] = '{pack_sample(5000, 5000, 32768, 32768, 32768, 32768,
                            32'hFFFF_FFFF, 0), 1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}};
      directed_rows[15] = '{pack_sample(-12800, 15360, 0, 32768, 0, 32768,
                            32'h0100_0000, 32'h0000_8000), 1'b0, zero_out};
      directed_rows[16] = '{pack_sample(16383, -16384, 32768, 32768, 32768, 32768,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, zero_out};
      directed_rows[17] = '{pack_sample(2560, 6400, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h8000,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, zero_out};
      directed_rows[18] = '{pack_sample(3000, 4000, 16'h2000, 16'h4000, 16'h4000, 16'h2000,
                            32'h0040_0000, 32'h0200_0000), 1'b0, zero_out};
      directed_rows[19] = '{pack_sample(9000, -1000, 16'h5000, 16'h1800, 16'h0800, 16'h7000,
                            32'h0000_0001, 32'h0000_0001), 1'b0, zero_out};

      reset = 1'b1;
      req_valid = 1'b0;
      req_temp_top = '0; req_temp_second = '0;
      req_swc_top = '0; req_swc_second = '0;
      req_root_frac_top = '0; req_root_frac_second = '0;
      req_n_deficit = '0; req_npp_available = '0;
      csr_write = 1'b0; csr_index = REG_TEMP_LOWER; csr_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < ROWS; i++) begin
         if (i == 3) begin
            drain();
            write_reg(REG_TEMP_LOWER, {16'd2560, -16'sd1280});
            write_reg(REG_TEMP_UPPER, {16'd10240, 16'd6400});
            write_reg(REG_SWC_BOUNDS, {16'h6000, 16'h1000});
            write_reg(REG_WATER_LINE, {16'h1000, 16'h0000});
            write_reg(REG_NFIX, 32'h00FF_FFFF);
            write_reg(REG_COST, 32'h0002_0000);
            write_reg(REG_MAX_FRAC, 32'h0000_4000);
         end
         offer(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].golden);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         random_config(ph);
         quiet = (ph == 1 || ph == 2);
         // The receiver holds off while the sender keeps offering, so the core backs up.
         if (ph == 2) hold_off_req = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Halfway through one phase the sender waits for every response first.
            if (ph == 5 && n == PHASE_ITEMS / 2) begin
               req_valid = 1'b0;
               while (pending_fixation.size() != 0) @(posedge clock);
               @(negedge clock);
            end
            offer(random_sample(), 1'b0, zero_out);
         end
         quiet = 1'b0;
      end

      drain();
      $display("Sent %0d soil samples over %0d register settings; %0d responses checked,",
               requests_sent, PHASES + 2, responses_seen);
      $display("%0d deficit-clamped and %0d cost-limited, %0d mismatches.",
               dlim_seen, clim_seen, mismatches);
      if (mismatches == 0 && pending_fixation.size() == 0)
         $display("nitrogen_fixation_rate_core test passed");
      else
         $display("nitrogen_fixation_rate_core test failed");
      $finish;
   end

endmodule

### files.f
hdl/nfr_pkg.sv
hdl/nfr_layer_front.sv
hdl/nfr_temp_div.sv
hdl/nfr_cost_div.sv
hdl/nitrogen_fixation_rate_core.sv
sim/tb_nitrogen_fixation_rate_core.sv
